// ===== hw/rtl/fsg_pkg.sv =====
// Shared types, constants and helper functions for the grey-to-bitmap
// error diffusion block. No dependencies.
package fsg_pkg;

  localparam int PIX_W  = 8;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 13;
  localparam int ERR_W  = 12;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 13'd4096;

  typedef logic signed [ERR_W-1:0] err_t;

  localparam err_t TOP_ERR_WHITE = -12'sd64;
  localparam err_t TOP_ERR_BLACK = 12'sd63;

  localparam logic signed [13:0] WHITE_LEVEL = 14'sd255;
  localparam logic signed [13:0] THRESHOLD   = 14'sd127;

  typedef struct packed {
    err_t ul;
    err_t up;
    err_t ur;
    err_t left;
  } fsg_nbr_t;

  typedef struct packed {
    logic white;
    err_t err;
  } fsg_res_t;

  // Error carried into the left edge of a buffer at the end of a row.
  function automatic err_t edge_err(logic [PIX_W-1:0] p, logic black);
    logic signed [9:0]  t;
    logic signed [9:0]  t_adj;
    logic signed [9:0]  half;
    logic signed [11:0] v;
    t     = 10'sd127 - $signed({2'b00, p});
    t_adj = t + $signed({9'b0, t[9]});
    half  = t_adj >>> 1;
    v     = $signed({4'b0000, p}) - (black ? 12'sd255 : 12'sd0) + 12'(half);
    return v;
  endfunction

endpackage

// ===== hw/rtl/fsg_pix_if.sv =====
// Input channel carrying one grey pixel per beat.
// Depends on fsg_pkg.
interface fsg_pix_if;
  import fsg_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

// ===== hw/rtl/fsg_mono_if.sv =====
// Result channel carrying one packed bitmap byte per beat.
// Depends on fsg_pkg.
interface fsg_mono_if;
  import fsg_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] mono_byte;
  logic              row_end;

  modport source (output valid, mono_byte, row_end, input ready);
  modport sink (input valid, mono_byte, row_end, output ready);
endinterface

// ===== hw/rtl/floyd_steinberg_grey_to_bitmap.sv =====
// Pixels are registered in s1 and completed bytes in the output register.
// Throughput: one pixel per cycle at any row position unless the output
// stalls; the running error feeds back through a single register stage, and
// the line store read for column i+2 is issued while column i is processed.
// Reset: synchronous, active low; width 4096; clears control and error state
// but up, col0, col1 and the line store. Depends on fsg_pkg, interfaces, RAM.
module floyd_steinberg_grey_to_bitmap #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [fsg_pkg::CFG_W-1:0] cfg_wdata,
  fsg_pix_if.sink                   in_pix,
  fsg_mono_if.source                out_mono
);
  import fsg_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int WW    = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

  logic [CFG_W-1:0]  width_r;
  logic [WW-1:0]     width_ext;
  logic [WW-1:0]     w_eff;

  logic              s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]  s1_pixel_r;
  logic              s1_fs_r;

  logic [CNT_W-1:0]  col_r, col_nxt;
  logic              top_r, top_nxt;
  logic              par_r, par_nxt;
  err_t              edge_r [2];
  err_t              edge_nxt [2];
  err_t              run_r, run_nxt;
  err_t              held_r, held_nxt;
  err_t              up_r, up_nxt;
  err_t              col0_r, col0_nxt;
  err_t              col1_r, col1_nxt;
  logic [BYTE_W-1:0] pack_r, pack_nxt;
  logic [PIX_W-1:0]  lpix_r, lpix_nxt;
  logic              fpb_r, fpb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  logic              fire;
  logic [CNT_W-1:0]  col_e;
  logic              top_e;
  logic              par_e;
  err_t              edge_e [2];
  logic [BYTE_W-1:0] pack_e;
  logic [CNT_W:0]    col_inc;
  logic [CNT_W:0]    col_inc2;
  logic              first;
  logic              last;
  logic              emit;
  err_t              ur_raw;
  err_t              store;
  logic [BYTE_W-1:0] pack_or;
  logic              black_first;
  fsg_nbr_t          nbr;
  fsg_res_t          res;
  logic              ram_re;
  logic [ERR_W-1:0]  ram_q;

  always_comb begin
    width_ext = WW'(width_r);
    if (width_ext == '0) begin
      w_eff = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
  end

  assign fire         = s1_valid_r && (!out_valid_r || out_mono.ready);
  assign in_pix.ready = !s1_valid_r || fire;

  always_comb begin
    col_e     = s1_fs_r ? '0 : col_r;
    top_e     = s1_fs_r | top_r;
    par_e     = s1_fs_r ? 1'b0 : par_r;
    edge_e[0] = s1_fs_r ? '0 : edge_r[0];
    edge_e[1] = s1_fs_r ? '0 : edge_r[1];
    pack_e    = s1_fs_r ? '0 : pack_r;
    col_inc   = {1'b0, col_e} + (CNT_W+1)'(1);
    col_inc2  = {1'b0, col_e} + (CNT_W+1)'(2);
    first     = (col_e == '0);
    last      = WW'(col_inc) >= w_eff;
    emit      = (col_e[2:0] == 3'd7) || last;

    ur_raw   = first ? col1_r : $signed(ram_q);
    nbr.up   = first ? col0_r : up_r;
    nbr.ur   = last ? '0 : ur_raw;
    nbr.ul   = first ? edge_e[par_e] : held_r;
    nbr.left = first ? (top_e ? '0 : edge_e[~par_e]) : run_r;

    store       = top_e ? (res.white ? TOP_ERR_WHITE : TOP_ERR_BLACK) : res.err;
    pack_or     = pack_e | (BYTE_W'(res.white) << col_e[2:0]);
    black_first = first ? !res.white : fpb_r;
    ram_re      = fire && !last && (col_inc2 < (CNT_W+1)'(MAX_WIDTH));
  end

  fsg_err_calc u_err_calc (
    .pixel (s1_pixel_r),
    .top   (top_e),
    .nbr   (nbr),
    .res   (res)
  );

  fsg_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (col_e),
    .wdata (store),
    .re    (ram_re),
    .raddr (col_inc2[CNT_W-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    col_nxt       = col_r;
    top_nxt       = top_r;
    par_nxt       = par_r;
    edge_nxt[0]   = edge_r[0];
    edge_nxt[1]   = edge_r[1];
    run_nxt       = run_r;
    held_nxt      = held_r;
    up_nxt        = up_r;
    col0_nxt      = col0_r;
    col1_nxt      = col1_r;
    pack_nxt      = pack_r;
    lpix_nxt      = lpix_r;
    fpb_nxt       = fpb_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;

    if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_pix.valid && in_pix.ready) begin
      s1_valid_nxt = 1'b1;
    end
    if (out_mono.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      edge_nxt[0] = edge_e[0];
      edge_nxt[1] = edge_e[1];
      run_nxt     = res.err;
      held_nxt    = nbr.up;
      up_nxt      = ur_raw;
      fpb_nxt     = black_first;
      if (first) begin
        col0_nxt = store;
      end
      if (col_e == CNT_W'(1)) begin
        col1_nxt = store;
      end
      pack_nxt = emit ? '0 : pack_or;
      if (emit) begin
        out_valid_nxt = 1'b1;
      end
      if (last) begin
        if (!top_e) begin
          edge_nxt[~par_e] = edge_err(lpix_r, black_first);
        end
        lpix_nxt = s1_pixel_r;
        top_nxt  = 1'b0;
        par_nxt  = ~par_e;
        col_nxt  = '0;
      end else begin
        top_nxt = top_e;
        par_nxt = par_e;
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= IMAGE_WIDTH_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      top_r       <= 1'b1;
      par_r       <= 1'b0;
      edge_r[0]   <= '0;
      edge_r[1]   <= '0;
      run_r       <= '0;
      held_r      <= '0;
      pack_r      <= '0;
      lpix_r      <= '0;
      fpb_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      par_r       <= par_nxt;
      edge_r[0]   <= edge_nxt[0];
      edge_r[1]   <= edge_nxt[1];
      run_r       <= run_nxt;
      held_r      <= held_nxt;
      pack_r      <= pack_nxt;
      lpix_r      <= lpix_nxt;
      fpb_r       <= fpb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && in_pix.ready) begin
      s1_pixel_r <= in_pix.pixel;
      s1_fs_r    <= in_pix.frame_start;
    end
    up_r   <= up_nxt;
    col0_r <= col0_nxt;
    col1_r <= col1_nxt;
    if (fire && emit) begin
      out_byte_r <= ~pack_or;
      out_end_r  <= last;
    end
  end

  assign out_mono.valid     = out_valid_r;
  assign out_mono.mono_byte = out_byte_r;
  assign out_mono.row_end   = out_end_r;

endmodule

// ===== hw/rtl/fsg_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module fsg_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fsg_err_calc.sv =====
// Weighted neighbor error sum, threshold and saturated new error for one pixel.
// Depends on fsg_pkg.
module fsg_err_calc (
  input  logic [fsg_pkg::PIX_W-1:0] pixel,
  input  logic                      top,
  input  fsg_pkg::fsg_nbr_t         nbr,
  output fsg_pkg::fsg_res_t         res
);
  import fsg_pkg::*;

  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;
  logic signed [12:0] quot;
  logic signed [12:0] corr;
  logic signed [13:0] grey;
  logic signed [13:0] err_raw;
  logic               white;

  always_comb begin
    sum = 17'(nbr.ul) + 17'(nbr.up) * 17'sd5 + 17'(nbr.ur) * 17'sd3
        + 17'(nbr.left) * 17'sd7;
    sum_adj = sum + (sum[16] ? 17'sd15 : 17'sd0);
    quot    = 13'(sum_adj >>> 4);
    corr    = top ? 13'(nbr.left) : quot;
    grey    = $signed({6'b000000, pixel}) + 14'(corr);
    white   = grey > THRESHOLD;
    err_raw = white ? grey - WHITE_LEVEL : grey;
    res.white = white;
    if (err_raw > 14'sd2047) begin
      res.err = 12'sd2047;
    end else if (err_raw < -14'sd2048) begin
      res.err = -12'sd2048;
    end else begin
      res.err = 12'(err_raw);
    end
  end

endmodule

// ===== hw/rtl/fsg_checker.sv =====
// Port-level checks for the grey-to-bitmap block and the bind that attaches them.
// Depends on fsg_pkg and the top level floyd_steinberg_grey_to_bitmap.
module fsg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fsg_pkg::BYTE_W-1:0] out_mono_byte,
  input logic                       out_row_end
);
  import fsg_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // A stalled result beat is neither withdrawn nor altered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mono_byte) && $stable(out_row_end))
    else $error("result payload changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result beat always comes from a pixel taken in through the s1 register.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result beat without a pixel behind it");

endmodule

bind floyd_steinberg_grey_to_bitmap fsg_checker u_fsg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_pix.valid),
  .in_ready      (in_pix.ready),
  .out_valid     (out_mono.valid),
  .out_ready     (out_mono.ready),
  .out_mono_byte (out_mono.mono_byte),
  .out_row_end   (out_mono.row_end)
);

// ===== verif/floyd_steinberg_grey_to_bitmap_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for floyd_steinberg_grey_to_bitmap: directed and random frames,
// predicted by an error diffusion model kept here, with random idling and back pressure.
// Depends on fsg_pkg, fsg_pix_if, fsg_mono_if and the block's RTL.
module floyd_steinberg_grey_to_bitmap_test;
  import fsg_pkg::*;

  localparam int LINE_DEPTH = 4096;
  localparam int PIPE_SETTLE = 4;
  localparam int MAX_GAP = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] mono_byte;
    logic              row_end;
  } mono_beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  fsg_pix_if  pix_ch ();
  fsg_mono_if mono_ch ();

  floyd_steinberg_grey_to_bitmap #(
    .MAX_WIDTH (LINE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_ch),
    .out_mono  (mono_ch)
  );

  mono_beat_t pending_bytes[$];
  int error_count;
  int idle_pct;
  int stall_pct;
  int hold_off;
  int pixels_sent;

  int               line_err[LINE_DEPTH];
  int               side_err[2];
  int               run_err;
  int               held_up;
  int               col;
  int               parity;
  int               last_row_pixel;
  bit               top_row;
  bit               first_black;
  logic [7:0]       pack;
  logic [CFG_W-1:0] img_width;

  function automatic int clip12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic logic [7:0] pick_pixel();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    if (r < 30) return 8'($urandom_range(135, 120));
    return 8'($urandom_range(255));
  endfunction

  // Dithers one grey pixel and queues the packed byte it completes, if any.
  task automatic diffuse_pixel(input logic [7:0] pix_in, input logic fs);
    int p, w, i, k, cur, g, ul, up, ur, lft, acc, pv;
    bit white, last;
    mono_beat_t beat;
    p = pix_in;
    if (fs) begin
      col = 0;
      top_row = 1'b1;
      parity = 0;
      side_err[0] = 0;
      side_err[1] = 0;
      pack = '0;
      run_err = 0;
      held_up = 0;
    end
    w = img_width;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    i = (col >= LINE_DEPTH) ? LINE_DEPTH - 1 : col;
    k = i % 8;
    last = (i + 1 >= w);
    cur = (parity ^ 1) & 1;
    if (top_row) begin
      if (i == 0) run_err = 0;
      g = p + run_err;
      white = (g > 127);
      run_err = clip12(white ? g - 255 : g);
      line_err[i] = white ? -64 : 63;
    end else begin
      ul = (i == 0) ? side_err[parity & 1] : held_up;
      lft = (i == 0) ? side_err[cur] : run_err;
      up = line_err[i];
      ur = (i + 1 < w) ? line_err[i + 1] : 0;
      acc = ul + 5 * up + 3 * ur + 7 * lft;
      g = p + acc / 16;
      white = (g > 127);
      run_err = clip12(white ? g - 255 : g);
      line_err[i] = run_err;
      held_up = up;
    end
    if (i == 0) first_black = !white;
    if (white) pack[k] = 1'b1;
    if (k == 7 || last) begin
      beat.mono_byte = ~pack;
      beat.row_end = last;
      pending_bytes.push_back(beat);
      pack = '0;
      if (last) begin
        if (!top_row) begin
          pv = last_row_pixel;
          side_err[cur] = clip12(pv - (first_black ? 255 : 0) + (127 - pv) / 2);
        end
        last_row_pixel = p;
        top_row = 1'b0;
        parity = parity ^ 1;
        col = 0;
      end else begin
        col = i + 1;
      end
    end else begin
      col = i + 1;
    end
  endtask

  task automatic send_pixel(input logic [7:0] pix_in, input logic fs);
    int gaps;
    gaps = 0;
    while (gaps < MAX_GAP && $urandom_range(99) < idle_pct) gaps++;
    repeat (gaps) begin
      @(negedge clk);
      pix_ch.valid <= 1'b0;
    end
    @(negedge clk);
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= pix_in;
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (pix_ch.ready !== 1'b1) @(posedge clk);
    diffuse_pixel(pix_in, fs);
    pixels_sent++;
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    wait_for_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    img_width = value;
  endtask

  task automatic test_directed_rows();
    logic [7:0] sample [0:19];
    sample = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd255, 8'd0, 8'd1, 8'd254, 8'd200, 8'd50,
               8'd255, 8'd255, 8'd0, 8'd0, 8'd127, 8'd128, 8'd64, 8'd192, 8'd3, 8'd252};
    write_width(13'd10);
    for (int n = 0; n < 20; n++) send_pixel(sample[n], n == 0);
  endtask

  task automatic test_narrow_widths();
    write_width(13'd0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    write_width(13'd1);
    send_pixel(8'd127, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd40, 1'b0);
  endtask

  task automatic test_frame_restart();
    write_width(13'd12);
    for (int n = 0; n < 5; n++) send_pixel(pick_pixel(), n == 0);
    for (int n = 0; n < 19; n++) send_pixel(pick_pixel(), n == 0);
    for (int n = 0; n < 24; n++) send_pixel(pick_pixel(), n == 0);
  endtask

  // The row in progress is past the new width, so its next pixel closes it.
  task automatic test_width_shrink();
    write_width(13'd16);
    for (int n = 0; n < 25; n++) send_pixel(pick_pixel(), n == 0);
    write_width(13'd5);
    for (int n = 0; n < 6; n++) send_pixel(pick_pixel(), 1'b0);
  endtask

  task automatic test_max_width();
    write_width(13'd8191);
    for (int n = 0; n < 40; n++) send_pixel(pick_pixel(), n == 0);
    write_width(IMAGE_WIDTH_RESET);
    for (int n = 0; n < 2; n++) send_pixel(pick_pixel(), 1'b0);
  endtask

  task automatic test_backpressure();
    write_width(13'd24);
    hold_off = 300;
    for (int n = 0; n < 72; n++) send_pixel(pick_pixel(), n == 0);
    wait_for_idle();
  endtask

  task automatic test_random_frames(input int quota);
    int first, w, h, rows_left, cap, r;
    bit fs;
    bit shrunk;
    first = pixels_sent;
    while (pixels_sent - first < quota) begin
      r = $urandom_range(99);
      if (r < 5) begin
        case ($urandom_range(3))
          0: w = 0;
          1: w = 1;
          2: w = 8;
          default: w = 9;
        endcase
        h = $urandom_range(5, 1);
      end else if (r < 20) begin
        w = $urandom_range(200, 41);
        h = $urandom_range(2, 1);
      end else begin
        w = $urandom_range(40, 1);
        h = $urandom_range(5, 1);
      end
      write_width(13'(w));
      shrunk = 1'b0;
      rows_left = h;
      send_pixel(pick_pixel(), 1'b1);
      if (col == 0) rows_left--;
      while (rows_left > 0) begin
        if (!shrunk && col > 0 && $urandom_range(99) < 2) begin
          shrunk = 1'b1;
          cap = (img_width == 0) ? 1 : int'(img_width);
          write_width(13'($urandom_range(cap, 1)));
        end
        fs = ($urandom_range(99) < 2);
        send_pixel(pick_pixel(), fs);
        if (col == 0) rows_left--;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    mono_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        mono_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        mono_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    mono_beat_t want;
    if (rst_n === 1'b1 && mono_ch.valid === 1'b1 && mono_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: mono_byte %h row_end %b", mono_ch.mono_byte, mono_ch.row_end);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (mono_ch.mono_byte !== want.mono_byte) begin
          $error("mono_byte: expected %h, actual %h", want.mono_byte, mono_ch.mono_byte);
          error_count++;
        end
        if (mono_ch.row_end !== want.row_end) begin
          $error("row_end: expected %b, actual %b", want.row_end, mono_ch.row_end);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.frame_start = 1'b0;
    error_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    pixels_sent = 0;
    foreach (line_err[n]) line_err[n] = 0;
    side_err[0] = 0;
    side_err[1] = 0;
    run_err = 0;
    held_up = 0;
    col = 0;
    parity = 0;
    last_row_pixel = 0;
    top_row = 1'b1;
    first_black = 1'b0;
    pack = '0;
    img_width = IMAGE_WIDTH_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_rows();
    test_narrow_widths();
    test_frame_restart();
    test_width_shrink();
    test_max_width();
    test_backpressure();

    test_random_frames(210);
    idle_pct = 66;
    test_random_frames(210);
    idle_pct = 0;
    stall_pct = 66;
    test_random_frames(210);
    idle_pct = 27;
    stall_pct = 27;
    test_random_frames(220);

    wait_for_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fsg_pkg.sv
hw/rtl/fsg_pix_if.sv
hw/rtl/fsg_mono_if.sv
hw/rtl/fsg_ram.sv
hw/rtl/fsg_err_calc.sv
hw/rtl/floyd_steinberg_grey_to_bitmap.sv
hw/rtl/fsg_checker.sv
verif/floyd_steinberg_grey_to_bitmap_test.sv
